### hdl/tableau_row_insertion_defines.svh
// Assertion macros shared by the tableau row insertion RTL.
`ifndef TABLEAU_ROW_INSERTION_DEFINES_SVH
`define TABLEAU_ROW_INSERTION_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property only while out of reset.
`define TRI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property at every edge, reset included.
`define TRI_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRI_ASSERT(lbl, clk, rstn, prop, msg)
`define TRI_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

### hdl/tri_pkg.sv
// Package with field types and parameter defaults for the tableau row insertion block.
`timescale 1ns / 1ps
package tri_pkg;
    localparam int LETTERS_DEF  = 8;
    localparam int CAPACITY_DEF = 255;

    localparam int LETTER_W = 4;
    localparam int ROW_W    = 3;
    localparam int COL_W    = 8;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [ROW_W-1:0]    t_row;
    typedef logic [COL_W-1:0]    t_col;
endpackage

### hdl/tri_ifs.sv
// Valid/ready channel interfaces for the input and result items.
`timescale 1ns / 1ps
interface tri_in_if;
    logic             valid;
    logic             ready;
    tri_pkg::t_letter letter;
    logic             start_new;

    modport source (output valid, output letter, output start_new, input ready);
    modport sink   (input valid, input letter, input start_new, output ready);
endinterface

interface tri_out_if;
    logic          valid;
    logic          ready;
    tri_pkg::t_row row_added;
    tri_pkg::t_col column_added;
    logic          rejected;

    modport source (output valid, output row_added, output column_added, output rejected,
                    input ready);
    modport sink   (input valid, input row_added, input column_added, input rejected,
                    output ready);
endinterface

### hdl/tableau_row_insertion.sv
// Top level of the tableau row insertion block.
`timescale 1ns / 1ps
`include "tableau_row_insertion_defines.svh"
// Schensted row insertion into a semistandard Young tableau over letters 1..LETTERS.
// Each row lives in one word of a small synchronous memory (one entry per row) that
// holds the count of every letter plus the row length, so the column of an appended
// box is read straight from the word. An accepted item issues the read of row 0; then
// each cycle takes the row data returned by the memory, bumps the smallest greater
// letter (or appends), writes the row back and issues the read of the next row,
// paced by the memory's registered read. An accepted item walks the rows in ST_WALK,
// then waits in ST_DONE until the output register is free and moves there; a rejected
// item (tableau at CAPACITY boxes) goes from ST_IDLE straight to ST_DONE. Items are
// handled one at a time; the next item is accepted as soon as the previous result
// has moved to the output register, even if it is not yet taken. start_new empties
// the tableau by dropping per-row valid bits, with no clearing pass; reset does the
// same. Letters of 0 count as 1 and letters above LETTERS count as LETTERS. Row and
// column are reported modulo their field widths.
module tableau_row_insertion #(
    parameter int LETTERS  = tri_pkg::LETTERS_DEF,
    parameter int CAPACITY = tri_pkg::CAPACITY_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tri_in_if.sink           i_in,
    tri_out_if.source        o_out
);
    localparam int IW    = $clog2(LETTERS);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST_ROW = IW'(LETTERS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Row memory: one word per row, no reset; rows are qualified by r_row_ok.
    logic [LETTERS:0][CNT_W-1:0] r_mem [LETTERS];
    logic [LETTERS:0][CNT_W-1:0] r_rd_word;
    logic                        r_rd_ok;

    logic [1:0]         r_state;
    logic [LETTERS-1:0] r_row_ok;
    logic [IW-1:0]      r_row;
    logic [IW-1:0]      r_x;
    logic [CNT_W-1:0]   r_total;

    // Finished result waiting for the output register.
    tri_pkg::t_row r_res_row;
    tri_pkg::t_col r_res_col;
    logic          r_res_rej;

    // Output register.
    logic          r_ov;
    tri_pkg::t_row r_o_row;
    tri_pkg::t_col r_o_col;
    logic          r_o_rej;

    logic                        w_accept;
    logic                        w_full;
    logic [IW-1:0]               w_x_in;
    logic                        w_rd_en;
    logic [IW-1:0]               w_rd_addr;
    logic                        w_wr_en;
    logic                        w_more;
    logic                        w_out_free;
    logic [LETTERS:0][CNT_W-1:0] w_new_word;
    logic                        w_found;
    logic [IW-1:0]               w_bump;
    logic [CNT_W-1:0]            w_len;

    assign i_in.ready   = (r_state == ST_IDLE);
    assign w_accept     = i_in.valid && i_in.ready;
    assign w_out_free   = !r_ov || o_out.ready;

    assign o_out.valid        = r_ov;
    assign o_out.row_added    = r_o_row;
    assign o_out.column_added = r_o_col;
    assign o_out.rejected     = r_o_rej;

    // Clamp the letter into range and turn it into a zero-based index.
    always_comb begin
        if (i_in.letter == '0) begin
            w_x_in = '0;
        end else if (int'(i_in.letter) > LETTERS) begin
            w_x_in = LAST_ROW;
        end else begin
            w_x_in = IW'(i_in.letter - tri_pkg::t_letter'(1));
        end
    end

    // A start_new item empties the tableau, so it can never be full.
    assign w_full = !i_in.start_new && (r_total >= CNT_W'(CAPACITY));

    tri_row_step #(
        .LETTERS (LETTERS),
        .CNT_W   (CNT_W)
    ) u_step (
        .i_word    (r_rd_word),
        .i_word_ok (r_rd_ok),
        .i_x       (r_x),
        .o_word    (w_new_word),
        .o_found   (w_found),
        .o_bump    (w_bump),
        .o_len     (w_len)
    );

    // Carry on to the next row while a letter was bumped and rows remain.
    assign w_more    = w_found && (r_row != LAST_ROW);
    assign w_wr_en   = (r_state == ST_WALK);
    assign w_rd_en   = (w_accept && !w_full) || (w_wr_en && w_more);
    assign w_rd_addr = w_accept ? '0 : r_row + IW'(1);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_row] <= w_new_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_word <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_row_ok  <= '0;
            r_total   <= '0;
            r_ov      <= 1'b0;
            r_rd_ok   <= 1'b0;
            r_row     <= '0;
            r_x       <= '0;
            r_res_row <= '0;
            r_res_col <= '0;
            r_res_rej <= 1'b0;
            r_o_row   <= '0;
            r_o_col   <= '0;
            r_o_rej   <= 1'b0;
        end else begin
            // Load the output register on hand-over, drop it once taken.
            if (r_state == ST_DONE && w_out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_in.start_new) begin
                            r_row_ok <= '0;
                            r_total  <= '0;
                            r_rd_ok  <= 1'b0;
                        end else begin
                            r_rd_ok  <= r_row_ok[0];
                        end
                        r_row <= '0;
                        r_x   <= w_x_in;
                        if (w_full) begin
                            // Reject: leave the tableau as it is.
                            r_res_row <= '0;
                            r_res_col <= '0;
                            r_res_rej <= 1'b1;
                            r_state   <= ST_DONE;
                        end else begin
                            r_state   <= ST_WALK;
                        end
                    end
                end
                ST_WALK: begin
                    r_row_ok[r_row] <= 1'b1;
                    if (w_more) begin
                        // Carry the bumped letter into the next row.
                        r_x     <= w_bump;
                        r_row   <= r_row + IW'(1);
                        r_rd_ok <= r_row_ok[r_row + IW'(1)];
                    end else begin
                        r_res_rej <= 1'b0;
                        r_state   <= ST_DONE;
                        if (w_found) begin
                            // Bump out of the last row: no box added.
                            r_res_row <= '0;
                            r_res_col <= '0;
                        end else begin
                            r_res_row <= tri_pkg::t_row'(r_row);
                            r_res_col <= tri_pkg::t_col'(w_len);
                            r_total   <= r_total + CNT_W'(1);
                        end
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_o_row <= r_res_row;
                        r_o_col <= r_res_col;
                        r_o_rej <= r_res_rej;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `TRI_ASSERT(a_total_cap, i_clk, i_rst_n, r_total <= CNT_W'(CAPACITY), "box count above capacity")
    `TRI_ASSERT(a_accept_next, i_clk, i_rst_n, w_accept |=> (r_state == ST_WALK || r_state == ST_DONE), "accepted item did not start")
    `TRI_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(r_ov) |-> $past(r_state) == ST_DONE, "result appeared outside hand-over")
    `TRI_ASSERT(a_reject_zero, i_clk, i_rst_n, (r_ov && r_o_rej) |-> (r_o_row == '0 && r_o_col == '0), "rejected result carries a position")
    `TRI_ASSERT(a_walk_row, i_clk, i_rst_n, (r_state == ST_WALK && r_row != '0) |-> $past(r_state) == ST_WALK, "row walk skipped a row")
    `TRI_ASSERT_RST(a_reset_out, i_clk, !i_rst_n |=> !r_ov, "output valid after reset")
endmodule

### hdl/tri_row_step.sv
// One row step of the insertion: find the letter to bump and build the new row word.
`timescale 1ns / 1ps
module tri_row_step #(
    parameter int LETTERS = tri_pkg::LETTERS_DEF,
    parameter int CNT_W   = 8,
    localparam int IW     = $clog2(LETTERS)
) (
    input  logic [LETTERS:0][CNT_W-1:0] i_word,   // counts, then row length on top
    input  logic                        i_word_ok,
    input  logic [IW-1:0]               i_x,
    output logic [LETTERS:0][CNT_W-1:0] o_word,
    output logic                        o_found,
    output logic [IW-1:0]               o_bump,
    output logic [CNT_W-1:0]            o_len
);
    logic [LETTERS:0][CNT_W-1:0] w_cur;

    // A row never written since the last clear reads as empty.
    assign w_cur = i_word_ok ? i_word : '0;
    assign o_len = w_cur[LETTERS];

    // Smallest letter above the carried one that is present in the row.
    always_comb begin
        o_found = 1'b0;
        o_bump  = '0;
        for (int b = LETTERS - 1; b >= 0; b--) begin
            if (b > int'(i_x) && w_cur[b] != '0) begin
                o_found = 1'b1;
                o_bump  = IW'(b);
            end
        end
    end

    always_comb begin
        o_word = w_cur;
        o_word[i_x] = w_cur[i_x] + CNT_W'(1);
        if (o_found) begin
            o_word[o_bump] = w_cur[o_bump] - CNT_W'(1);
        end else begin
            o_word[LETTERS] = w_cur[LETTERS] + CNT_W'(1);
        end
    end
endmodule

### test/testbench.sv
// Self-checking testbench for the tableau row insertion block.
`timescale 1ns / 1ps
module testbench;
    localparam int LETTERS           = tri_pkg::LETTERS_DEF;
    localparam int CAPACITY          = tri_pkg::CAPACITY_DEF;
    localparam int HALF_PERIOD       = 10;
    // Drain wait covers an item that lands in the last row, plus margin for the output register.
    localparam int DRAIN_CYCLES      = LETTERS + 12;
    localparam int LONG_STALL_CYCLES = 250;

    typedef struct packed {
        tri_pkg::t_row row_added;
        tri_pkg::t_col column_added;
        logic          rejected;
    } t_box;

    // One row of the directed table; known marks a hand-typed expectation.
    typedef struct {
        tri_pkg::t_letter letter;
        logic             start_new;
        bit               known;
        t_box             box;
    } t_directed_row;

    // What the sender offered, kept until the handshake takes it.
    typedef struct {
        bit   known;
        t_box box;
    } t_offer;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tri_in_if  in_ch ();
    tri_out_if out_ch ();

    tableau_row_insertion uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Idle rates in percent, set per phase by the stimulus and read by the drivers.
    int send_idle_pct       = 0;
    int recv_stall_pct      = 0;
    // Bump to ask the receiver for one long hold-off.
    int long_stall_requests = 0;
    int fail_count          = 0;

    t_offer offered_items  [$];
    t_box   expected_boxes [$];

    // ------------------------------------------------------------------
    // Tableau model: per-row letter counts and the number of boxes.
    // ------------------------------------------------------------------
    logic [7:0] row_counts [LETTERS][LETTERS];
    logic [7:0] box_total;

    function automatic void clear_tableau();
        foreach (row_counts[r, k]) row_counts[r][k] = 8'd0;
        box_total = 8'd0;
    endfunction

    // Insert one letter row by row; return where the new box appeared.
    function automatic t_box predict_insertion(tri_pkg::t_letter letter_in, logic start_new);
        int   carried;
        int   bumped;
        int   width;
        int   r;
        int   b;
        int   k;
        t_box box;
        if (start_new) clear_tableau();
        // Clamp out-of-range letters into the alphabet.
        carried = int'(letter_in);
        if (carried < 1) carried = 1;
        if (carried > LETTERS) carried = LETTERS;
        box = '0;
        // Reject a full tableau and leave it untouched.
        if (int'(box_total) >= CAPACITY) begin
            box.rejected = 1'b1;
            return box;
        end
        for (r = 0; r < LETTERS; r++) begin
            // Find the smallest letter in this row strictly above the carried one.
            bumped = 0;
            for (b = LETTERS; b > carried; b--) begin
                if (row_counts[r][b-1] != 8'd0) bumped = b;
            end
            if (bumped != 0) begin
                row_counts[r][bumped-1]  = row_counts[r][bumped-1] - 8'd1;
                row_counts[r][carried-1] = row_counts[r][carried-1] + 8'd1;
                carried = bumped;
            end else begin
                // Append at the end of the row; its length is the new column.
                width = 0;
                for (k = 0; k < LETTERS; k++) width += int'(row_counts[r][k]);
                row_counts[r][carried-1] = row_counts[r][carried-1] + 8'd1;
                box.row_added    = tri_pkg::t_row'(r);
                box.column_added = tri_pkg::t_col'(width);
                box_total        = box_total + 8'd1;
                return box;
            end
        end
        return box;
    endfunction

    initial clear_tableau();

    function automatic void check_field(string field, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: sample both channels at the rising edge. Check the
    // result first so an item taken on the same edge cannot mask a
    // result that nothing was waiting for.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_port
        t_box   want;
        t_box   model;
        t_offer offer;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_boxes.size() == 0) begin
                    $error("result with no item outstanding: row %0d column %0d rejected %0b",
                           out_ch.row_added, out_ch.column_added, out_ch.rejected);
                    fail_count++;
                end else begin
                    want = expected_boxes.pop_front();
                    check_field("row_added", int'(want.row_added), int'(out_ch.row_added));
                    check_field("column_added", int'(want.column_added),
                                int'(out_ch.column_added));
                    check_field("rejected", int'(want.rejected), int'(out_ch.rejected));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                // Advance the model on every accepted item, even where the table types the result.
                model = predict_insertion(in_ch.letter, in_ch.start_new);
                offer = offered_items.pop_front();
                expected_boxes = {expected_boxes, (offer.known ? offer.box : model)};
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: decide ready at each falling edge. A long hold-off,
    // when requested, is counted down here while the sender keeps
    // offering, so the block fills and stalls its input.
    // ------------------------------------------------------------------
    initial begin : drive_ready
        int hold_left;
        int stalls_seen;
        hold_left    = 0;
        stalls_seen  = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_stall_requests != stalls_seen) begin
                stalls_seen = long_stall_requests;
                hold_left   = LONG_STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender. Called at a falling edge; returns at the falling edge
    // after the item is taken. Valid stays high into the next item
    // when no idle cycle is drawn, so it gets one assignment per step.
    // ------------------------------------------------------------------
    task automatic offer_item(tri_pkg::t_letter letter_in, logic start_in, bit known,
                              t_box box);
        t_offer offer;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        offer.known = known;
        offer.box   = box;
        offered_items = {offered_items, offer};
        in_ch.valid     <= 1'b1;
        in_ch.letter    <= letter_in;
        in_ch.start_new <= start_in;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Mostly letters of the alphabet; now and then any 4-bit value.
    function automatic tri_pkg::t_letter random_letter();
        if ($urandom_range(9) < 8) return tri_pkg::t_letter'($urandom_range(LETTERS, 1));
        return tri_pkg::t_letter'($urandom_range(15, 0));
    endfunction

    // Random content with an occasional fresh tableau.
    task automatic send_random(int count);
        repeat (count) offer_item(random_letter(), ($urandom_range(23) == 0), 1'b0, '0);
    endtask

    // Fill an empty tableau to capacity with non-decreasing letters, so every
    // box lands in the top row and the column reaches CAPACITY-1. Then
    // hit the full tableau, and finally clear it with start_new.
    task automatic fill_tableau();
        int   cur;
        t_box reject_box;
        reject_box          = '0;
        reject_box.rejected = 1'b1;
        cur = 1;
        offer_item(tri_pkg::t_letter'(cur), 1'b1, 1'b0, '0);
        repeat (CAPACITY - 1) begin
            if (cur < LETTERS && $urandom_range(15) == 0) cur++;
            offer_item(tri_pkg::t_letter'(cur), 1'b0, 1'b0, '0);
        end
        repeat (12) offer_item(tri_pkg::t_letter'($urandom_range(15, 0)), 1'b0, 1'b1,
                               reject_box);
        offer_item(random_letter(), 1'b1, 1'b1, '{3'd0, 8'd0, 1'b0});
    endtask

    // Directed rows: a falling staircase 8..1 reaches every row; then the
    // out-of-range letters, start_new, and a few bumps left to the model.
    t_directed_row directed_rows [18] = '{
        '{4'd1,  1'b0, 1'b1, '{3'd0, 8'd0, 1'b0}},
        '{4'd8,  1'b1, 1'b1, '{3'd0, 8'd0, 1'b0}},
        '{4'd7,  1'b0, 1'b1, '{3'd1, 8'd0, 1'b0}},
        '{4'd6,  1'b0, 1'b1, '{3'd2, 8'd0, 1'b0}},
        '{4'd5,  1'b0, 1'b1, '{3'd3, 8'd0, 1'b0}},
        '{4'd4,  1'b0, 1'b1, '{3'd4, 8'd0, 1'b0}},
        '{4'd3,  1'b0, 1'b1, '{3'd5, 8'd0, 1'b0}},
        '{4'd2,  1'b0, 1'b1, '{3'd6, 8'd0, 1'b0}},
        '{4'd1,  1'b0, 1'b1, '{3'd7, 8'd0, 1'b0}},
        '{4'd0,  1'b0, 1'b1, '{3'd0, 8'd1, 1'b0}},
        '{4'd15, 1'b0, 1'b1, '{3'd0, 8'd2, 1'b0}},
        '{4'd9,  1'b0, 1'b1, '{3'd0, 8'd3, 1'b0}},
        '{4'd2,  1'b1, 1'b1, '{3'd0, 8'd0, 1'b0}},
        '{4'd1,  1'b0, 1'b0, '{3'd0, 8'd0, 1'b0}},
        '{4'd3,  1'b0, 1'b0, '{3'd0, 8'd0, 1'b0}},
        '{4'd12, 1'b1, 1'b1, '{3'd0, 8'd0, 1'b0}},
        '{4'd5,  1'b0, 1'b0, '{3'd0, 8'd0, 1'b0}},
        '{4'd5,  1'b0, 1'b0, '{3'd0, 8'd0, 1'b0}}
    };

    initial begin : stimulus
        in_ch.valid     = 1'b0;
        in_ch.letter    = '0;
        in_ch.start_new = 1'b0;
        // Hold reset from the start, release it at a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, both sides always ready.
        foreach (directed_rows[i]) begin
            offer_item(directed_rows[i].letter, directed_rows[i].start_new,
                       directed_rows[i].known, directed_rows[i].box);
        end

        // No idling.
        send_random(150);

        // Long receiver hold-off while the sender keeps pushing.
        long_stall_requests++;
        send_random(40);

        // Sender mostly idle.
        send_idle_pct = 84;
        send_random(120);

        // Receiver mostly stalling.
        send_idle_pct  = 0;
        recv_stall_pct = 84;
        send_random(120);

        // Light idling on both sides while filling to capacity.
        send_idle_pct  = 7;
        recv_stall_pct = 7;
        fill_tableau();

        in_ch.valid <= 1'b0;

        // Drain: wait for every result, then let stray results show up.
        while (expected_boxes.size() != 0 || offered_items.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
